@@ rtl/core/tnfk_pkg.sv @@
`timescale 1ns / 1ps

package tnfk_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 5;

  localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(5);
  localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(MAX_ENTRIES - 1);

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_OVERWROTE = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_DUMP     = 3'd4;

  typedef struct packed {
    logic        action;
    logic [63:0] item_key;
    logic [31:0] frequency;
  } in_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             entry_valid;
    logic [63:0]      out_key;
    logic [31:0]      out_frequency;
    logic [CNT_W-1:0] held_count;
    logic [31:0]      minimum_frequency;
    logic             last;
  } out_res_t;

endpackage

@@ rtl/core/top_n_frequency_keeper.sv @@
// Offer request: key scan over every slot, decide, write, minimum rescan over every slot, finish;
// a rejected offer skips the rescan. A new request is taken only once busy is low.
// Dump: one entry per cycle for each valid slot, in slot order, with no result for empty slots;
// an empty dump gives a single result with entry_valid low. One request at a time, set by the slot-by-slot scans.
// Results appear for one cycle on out_valid; the receiver cannot stall them.
// Synchronous active-low reset clears valid bits, count, minimum, keep_count (to 5), not slots.
`timescale 1ns / 1ps

module top_n_frequency_keeper import tnfk_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_req_t          in_data,
  output logic             out_valid,
  output out_res_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_WRITE  = 7'b0001000,
    S_RESCAN = 7'b0010000,
    S_DUMP   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] key_mem [MAX_ENTRIES];
  logic [31:0] freq_mem [MAX_ENTRIES];
  logic [63:0] rd_key_r;
  logic [31:0] rd_freq_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic [MAX_ENTRIES-1:0] slot_valid_r;
  logic [CNT_W-1:0]       count_r;
  logic [31:0]            min_freq_r;
  logic [IDX_W-1:0]       min_slot_r;
  logic [CNT_W-1:0]       keep_r;

  in_req_t          in_q_r;
  logic [IDX_W-1:0] idx_r;
  logic             issue_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             found_r;
  logic [2:0]       status_r;
  logic [IDX_W-1:0] wr_slot_r;
  logic [63:0]      evict_key_r;
  logic [31:0]      evict_freq_r;
  logic             out_valid_r;
  out_res_t         out_r;

  logic [CNT_W-1:0]       cap;
  logic [IDX_W-1:0]       free_slot;
  logic [MAX_ENTRIES-1:0] above_mask;
  logic                   later_valid;
  logic                   pend_last;
  logic                   is_rep;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pend_last = pend_r && (pend_idx_r == LAST_IDX);
  assign is_rep    = (status_r == ST_REPLACED);

  always_comb begin
    if (keep_r == '0) begin
      cap = CNT_W'(1);
    end else if (keep_r > COUNT_MAX) begin
      cap = COUNT_MAX;
    end else begin
      cap = keep_r;
    end
  end

  always_comb begin
    free_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) free_slot = IDX_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      above_mask[i] = (IDX_W'(i) > pend_idx_r);
    end
    later_valid = |(slot_valid_r & above_mask);
  end

  assign rd_addr = (state_r == S_DECIDE) ? min_slot_r : idx_r;
  assign mem_we  = (state_r == S_WRITE) && (status_r != ST_REJECTED);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_slot_r]  <= in_q_r.item_key;
      freq_mem[wr_slot_r] <= in_q_r.frequency;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_freq_r <= freq_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.action) begin
            state_nxt = (|slot_valid_r) ? S_DUMP : S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN:   if (pend_last) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_WRITE;
      S_WRITE:  state_nxt = (status_r == ST_REJECTED) ? S_FINISH : S_RESCAN;
      S_RESCAN: if (pend_last) state_nxt = S_FINISH;
      S_DUMP:   if (pend_last) state_nxt = S_IDLE;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      count_r      <= '0;
      min_freq_r   <= '0;
      min_slot_r   <= '0;
      keep_r       <= KEEP_RESET;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      issue_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      if (cfg_valid && cfg_ready) keep_r <= cfg_data;

      if (issue_r && (state_r == S_SCAN || state_r == S_RESCAN || state_r == S_DUMP)) begin
        pend_r     <= 1'b1;
        pend_idx_r <= idx_r;
        if (idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_q_r   <= in_data;
            idx_r    <= '0;
            issue_r  <= 1'b1;
            hit_r    <= 1'b0;
            status_r <= ST_DUMP;
          end
        end
        S_SCAN: begin
          if (pend_r && slot_valid_r[pend_idx_r] && !hit_r &&
              rd_key_r == in_q_r.item_key) begin
            hit_r     <= 1'b1;
            hit_idx_r <= pend_idx_r;
          end
        end
        S_DECIDE: begin
          if (hit_r) begin
            status_r  <= ST_OVERWROTE;
            wr_slot_r <= hit_idx_r;
          end else if (count_r < cap) begin
            status_r  <= ST_ADDED;
            wr_slot_r <= free_slot;
          end else if (in_q_r.frequency > min_freq_r && slot_valid_r[min_slot_r]) begin
            status_r  <= ST_REPLACED;
            wr_slot_r <= min_slot_r;
          end else begin
            status_r  <= ST_REJECTED;
          end
        end
        S_WRITE: begin
          evict_key_r  <= rd_key_r;
          evict_freq_r <= rd_freq_r;
          if (status_r == ST_ADDED) begin
            slot_valid_r[wr_slot_r] <= 1'b1;
            count_r                 <= count_r + CNT_W'(1);
          end
          if (status_r != ST_REJECTED) begin
            idx_r      <= '0;
            issue_r    <= 1'b1;
            found_r    <= 1'b0;
            min_freq_r <= '0;
            min_slot_r <= '0;
          end
        end
        S_RESCAN: begin
          if (pend_r && slot_valid_r[pend_idx_r] && (!found_r || rd_freq_r < min_freq_r)) begin
            found_r    <= 1'b1;
            min_freq_r <= rd_freq_r;
            min_slot_r <= pend_idx_r;
          end
        end
        S_DUMP: begin
          if (pend_r && slot_valid_r[pend_idx_r]) begin
            out_valid_r <= 1'b1;
            out_r <= '{status: ST_DUMP, entry_valid: 1'b1, out_key: rd_key_r,
                       out_frequency: rd_freq_r, held_count: count_r,
                       minimum_frequency: min_freq_r, last: !later_valid};
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          out_r <= '{status: status_r, entry_valid: is_rep,
                     out_key: is_rep ? evict_key_r : 64'd0,
                     out_frequency: is_rep ? evict_freq_r : 32'd0,
                     held_count: count_r, minimum_frequency: min_freq_r, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == count_r)
    else $error("entry count differs from valid slots");

  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.held_count <= COUNT_MAX)
    else $error("held count above capacity");

  a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.entry_valid) |->
      (out_data.status == ST_REPLACED || out_data.status == ST_DUMP))
    else $error("entry carried on a status without one");

  a_offer_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DUMP) |-> out_data.last)
    else $error("offer result not marked last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last && out_data.status != ST_DUMP) |-> !busy)
    else $error("still busy after final result");

endmodule

@@ test/top_n_frequency_keeper_tb.sv @@
`timescale 1ns / 1ps

module top_n_frequency_keeper_tb;
  import tnfk_pkg::*;

  localparam logic ACT_OFFER    = 1'b0;
  localparam logic ACT_DUMP     = 1'b1;
  localparam int   QUIET_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 60;
  localparam int   PLAN_ROWS    = 24;

  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cfg_val;
    in_req_t          req;
    logic             known;
    out_res_t         want;
  } plan_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  in_req_t          in_data   = '0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             out_valid;
  out_res_t         out_data;
  logic             cfg_ready;

  logic [63:0]      tbl_key  [MAX_ENTRIES];
  logic [31:0]      tbl_freq [MAX_ENTRIES];
  logic             tbl_held [MAX_ENTRIES];
  logic [CNT_W-1:0] tbl_count;
  logic [CNT_W-1:0] tbl_keep;
  logic [31:0]      tbl_min;
  int               tbl_min_slot;

  out_res_t  pending_outcomes[$];
  plan_row_t plan [PLAN_ROWS];
  int        fails = 0;
  int        quiet = 0;

  top_n_frequency_keeper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void find_minimum();
    logic found = 1'b0;
    tbl_min      = '0;
    tbl_min_slot = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (tbl_held[i] && (!found || tbl_freq[i] < tbl_min)) begin
        found        = 1'b1;
        tbl_min      = tbl_freq[i];
        tbl_min_slot = i;
      end
    end
  endfunction

  function automatic out_res_t outcome(logic [2:0] st, logic v, logic [63:0] k,
                                       logic [31:0] f, logic l);
    out_res_t o;
    o.status            = st;
    o.entry_valid       = v;
    o.out_key           = k;
    o.out_frequency     = f;
    o.held_count        = tbl_count;
    o.minimum_frequency = tbl_min;
    o.last              = l;
    return o;
  endfunction

  function automatic void table_apply(in_req_t r);
    int          total = 0;
    int          shown = 0;
    int          hit   = -1;
    int          room  = -1;
    int          cap;
    logic [63:0] old_key;
    logic [31:0] old_freq;
    if (r.action == ACT_DUMP) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (tbl_held[i]) total++;
      if (total == 0)
        pending_outcomes.push_back(outcome(ST_DUMP, 1'b0, '0, '0, 1'b1));
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (tbl_held[i]) begin
          shown++;
          pending_outcomes.push_back(outcome(ST_DUMP, 1'b1, tbl_key[i], tbl_freq[i],
                                             shown == total));
        end
      end
      return;
    end
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (tbl_held[i] && tbl_key[i] == r.item_key) hit = i;
    if (hit >= 0) begin
      tbl_freq[hit] = r.frequency;
      find_minimum();
      pending_outcomes.push_back(outcome(ST_OVERWROTE, 1'b0, '0, '0, 1'b1));
      return;
    end
    cap = (tbl_keep == 0) ? 1 : (tbl_keep > COUNT_MAX) ? MAX_ENTRIES : int'(tbl_keep);
    for (int i = MAX_ENTRIES - 1; i >= 0; i--)
      if (!tbl_held[i]) room = i;
    if (tbl_count < cap && room >= 0) begin
      tbl_held[room] = 1'b1;
      tbl_key[room]  = r.item_key;
      tbl_freq[room] = r.frequency;
      tbl_count      = tbl_count + CNT_W'(1);
      find_minimum();
      pending_outcomes.push_back(outcome(ST_ADDED, 1'b0, '0, '0, 1'b1));
      return;
    end
    if (r.frequency > tbl_min && tbl_held[tbl_min_slot]) begin
      old_key                = tbl_key[tbl_min_slot];
      old_freq               = tbl_freq[tbl_min_slot];
      tbl_key[tbl_min_slot]  = r.item_key;
      tbl_freq[tbl_min_slot] = r.frequency;
      find_minimum();
      pending_outcomes.push_back(outcome(ST_REPLACED, 1'b1, old_key, old_freq, 1'b1));
      return;
    end
    pending_outcomes.push_back(outcome(ST_REJECTED, 1'b0, '0, '0, 1'b1));
  endfunction

  function automatic plan_row_t op_offer(logic [63:0] k, logic [31:0] f);
    plan_row_t p = '0;
    p.req.action    = ACT_OFFER;
    p.req.item_key  = k;
    p.req.frequency = f;
    return p;
  endfunction

  function automatic plan_row_t op_dump();
    plan_row_t p = '0;
    p.req.action = ACT_DUMP;
    return p;
  endfunction

  function automatic plan_row_t op_cfg(logic [CNT_W-1:0] v);
    plan_row_t p = '0;
    p.is_cfg  = 1'b1;
    p.cfg_val = v;
    return p;
  endfunction

  function automatic plan_row_t with_result(plan_row_t p, logic [2:0] st, logic v,
                                            logic [63:0] k, logic [31:0] f,
                                            logic [CNT_W-1:0] cnt, logic [31:0] mn);
    p.known = 1'b1;
    p.want  = '{st, v, k, f, cnt, mn, 1'b1};
    return p;
  endfunction

  function automatic in_req_t draw_req();
    in_req_t r;
    int      pick;
    int      s;
    pick     = $urandom_range(99);
    s        = $urandom_range(MAX_ENTRIES - 1);
    r.action = (pick < 15) ? ACT_DUMP : ACT_OFFER;
    if (pick >= 15 && pick < 45 && tbl_held[s])
      r.item_key = tbl_key[s];
    else
      r.item_key = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: r.frequency = $urandom;
      4, 5, 6:    r.frequency = $urandom_range(15);
      7:          r.frequency = $urandom_range(1) ? '1 : '0;
      default:    r.frequency = tbl_min + 32'($urandom_range(4)) - 32'd2;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic send_req(in_req_t r);
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    table_apply(r);
  endtask

  task automatic idle_some(int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic settle(int tail);
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0 || busy);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_keep(logic [CNT_W-1:0] v);
    settle(8);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tbl_keep = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int idle_pct, int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 || $urandom_range(19) == 0) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
      end else begin
        idle_some(idle_pct);
      end
      send_req(draw_req());
    end
  endtask

  always @(posedge clk) begin : watch_results
    out_res_t e;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = pending_outcomes.pop_front();
        check_field("status", 64'(e.status), 64'(out_data.status));
        check_field("entry_valid", 64'(e.entry_valid), 64'(out_data.entry_valid));
        check_field("out_key", e.out_key, out_data.out_key);
        check_field("out_frequency", 64'(e.out_frequency), 64'(out_data.out_frequency));
        check_field("held_count", 64'(e.held_count), 64'(out_data.held_count));
        check_field("minimum_frequency", 64'(e.minimum_frequency),
                    64'(out_data.minimum_frequency));
        check_field("last", 64'(e.last), 64'(out_data.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tbl_held[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_freq[i] = '0;
    end
    tbl_count    = '0;
    tbl_min      = '0;
    tbl_min_slot = 0;
    tbl_keep     = KEEP_RESET;

    // capacity 0 behaves as 1, also once the table holds an entry
    plan = '{
      with_result(op_dump(), ST_DUMP, 1'b0, '0, '0, 5'd0, 32'h0),
      op_cfg(5'd0),
      with_result(op_offer(64'h0, 32'h0), ST_ADDED, 1'b0, '0, '0, 5'd1, 32'h0),
      with_result(op_offer('1, '1), ST_REPLACED, 1'b1, 64'h0, 32'h0, 5'd1, '1),
      with_result(op_offer(64'h5555_5555_5555_5555, '1), ST_REJECTED, 1'b0, '0, '0,
                  5'd1, '1),
      op_cfg(5'd1),
      op_offer(64'h5555_5555_5555_5555, 32'h0),
      op_cfg(5'd5),
      op_offer(64'h5555_5555_5555_5555, 32'h0001_0000),
      op_offer(64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000),
      op_offer(64'h0123_4567_89AB_CDEF, 32'h0000_0001),
      op_offer(64'hFEDC_BA98_7654_3210, 32'h7FFF_FFFF),
      op_offer(64'h7, 32'h0000_0001),
      op_offer(64'h0123_4567_89AB_CDEF, 32'h0000_0020),
      op_offer(64'h9, 32'h0000_0021),
      op_dump(),
      op_offer('1, 32'h0),
      op_cfg(5'd2),
      op_offer(64'h10, 32'h0),
      op_offer(64'h11, 32'h3),
      op_cfg(5'd31),
      op_offer(64'h12, 32'h0000_FFFF),
      op_dump(),
      op_cfg(5'd16)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_keep(plan[i].cfg_val);
      end else begin
        idle_some(30);
        send_req(plan[i].req);
        if (plan[i].known) begin
          void'(pending_outcomes.pop_back());
          pending_outcomes.push_back(plan[i].want);
        end
      end
    end

    write_keep(5'd8);
    run_phase(30, 31);
    write_keep(5'd3);
    run_phase(52, 31);
    write_keep(5'd17);
    run_phase(0, 30);

    settle(DRAIN_CYCLES);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tnfk_pkg.sv
rtl/core/top_n_frequency_keeper.sv
test/top_n_frequency_keeper_tb.sv
